>>> rtl/ssd_pkg.sv
// Shared types, constants and segment encode functions for the
// seven-segment shift driver. No dependencies.

package ssd_pkg;

  localparam int unsigned ValueW = 10;
  localparam int unsigned PointW = 2;
  localparam int unsigned SegWordW = 32;

  // Decimal point codes
  localparam logic [PointW-1:0] DpNone   = 2'd0;
  localparam logic [PointW-1:0] DpFirst  = 2'd1;
  localparam logic [PointW-1:0] DpSecond = 2'd2;
  localparam logic [PointW-1:0] DpThird  = 2'd3;

  localparam logic [SegWordW-1:0] DpFirstBit  = 32'h8000_0000;
  localparam logic [SegWordW-1:0] DpSecondBit = 32'h0000_0800;
  localparam logic [SegWordW-1:0] DpThirdBit  = 32'h0000_8000;

  typedef logic [SegWordW-1:0] seg_word_t;

  // Queue status seen by the front and back parts
  typedef struct packed {
    logic empty;
    logic full;
  } ssd_qstat_t;

  // Segment pattern of the first and third digits (first digit sits 16 up)
  function automatic logic [15:0] seg_outer(input logic [3:0] d);
    logic [15:0] s;
    case (d)
      4'd0:    s = 16'h7007;
      4'd1:    s = 16'h4001;
      4'd2:    s = 16'h300B;
      4'd3:    s = 16'h600B;
      4'd4:    s = 16'h400D;
      4'd5:    s = 16'h600E;
      4'd6:    s = 16'h700E;
      4'd7:    s = 16'h4003;
      4'd8:    s = 16'h700F;
      4'd9:    s = 16'h600F;
      default: s = 16'h0000;
    endcase
    return s;
  endfunction

  // Segment pattern of the second digit
  function automatic logic [15:0] seg_middle(input logic [3:0] d);
    logic [15:0] s;
    case (d)
      4'd0:    s = 16'h0770;
      4'd1:    s = 16'h0410;
      4'd2:    s = 16'h03B0;
      4'd3:    s = 16'h06B0;
      4'd4:    s = 16'h04D0;
      4'd5:    s = 16'h06E0;
      4'd6:    s = 16'h07E0;
      4'd7:    s = 16'h0430;
      4'd8:    s = 16'h07F0;
      4'd9:    s = 16'h06F0;
      default: s = 16'h0000;
    endcase
    return s;
  endfunction

  // Bar segments, upper half of the word
  function automatic logic [15:0] bar_bits(input logic [2:0] idx);
    logic [15:0] s;
    case (idx)
      3'd0:    s = 16'h0100;
      3'd1:    s = 16'h0300;
      3'd2:    s = 16'h0700;
      3'd3:    s = 16'h0F00;
      3'd4:    s = 16'h0F80;
      3'd5:    s = 16'h0FC0;
      3'd6:    s = 16'h0FE0;
      3'd7:    s = 16'h0FF0;
      default: s = 16'h0000;
    endcase
    return s;
  endfunction

  // value*8/500 saturated at 7: count the crossed thresholds
  function automatic logic [2:0] bar_index(input logic [ValueW-1:0] v);
    logic [2:0] idx;
    idx = 3'd0;
    if (v >= 10'd63)  idx = 3'd1;
    if (v >= 10'd125) idx = 3'd2;
    if (v >= 10'd188) idx = 3'd3;
    if (v >= 10'd250) idx = 3'd4;
    if (v >= 10'd313) idx = 3'd5;
    if (v >= 10'd375) idx = 3'd6;
    if (v >= 10'd438) idx = 3'd7;
    return idx;
  endfunction

endpackage

>>> rtl/ssd_front.sv
// Front part: accepts update beats, splits the value into digits and
// builds the segment word. Depends on ssd_pkg.

module ssd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [15:0]         s_tdata,   // [9:0] display_value, [11:10] point_position,
                                         // [12] bar_enable, rest zero
  input  ssd_pkg::ssd_qstat_t qstat_i,
  output logic                push_o,
  output ssd_pkg::seg_word_t  word_o
);
  import ssd_pkg::*;

  logic [ValueW-1:0] value;
  logic [PointW-1:0] point;
  logic              bar_en;

  logic [15:0] prod100;
  logic [17:0] prod10;
  logic [3:0]  q100;
  logic [6:0]  q10;
  logic [3:0]  hund, tens, units;
  logic [6:0]  tens_w;
  logic [9:0]  units_w;
  seg_word_t   word_d, word_q;
  logic        valid_q;

  assign value  = s_tdata[9:0];
  assign point  = s_tdata[11:10];
  assign bar_en = s_tdata[12];

  // Digit split by reciprocal multiply, exact for 0..1023
  always_comb begin
    prod100 = {6'd0, value} * 16'd41;
    prod10  = {8'd0, value} * 18'd205;
    q100    = prod100[15:12];
    q10     = prod10[17:11];
    hund    = (q100 >= 4'd10) ? q100 - 4'd10 : q100;
    tens_w  = q10 - 7'({3'd0, q100} * 7'd10);
    units_w = value - 10'({3'd0, q10} * 10'd10);
    tens    = tens_w[3:0];
    units   = units_w[3:0];
  end

  // Word assembly
  always_comb begin
    word_d = {seg_outer(hund), 16'h0000}
           | {16'h0000, seg_middle(tens)}
           | {16'h0000, seg_outer(units)};
    if (bar_en) begin
      word_d = word_d | {bar_bits(bar_index(value)), 16'h0000};
    end
    case (point)
      DpFirst:  word_d = word_d | DpFirstBit;
      DpSecond: word_d = word_d | DpSecondBit;
      DpThird:  word_d = word_d | DpThirdBit;
      default:  word_d = word_d;
    endcase
  end

  // Output register toward the queue
  assign push_o   = valid_q && !qstat_i.full;
  assign s_tready = !valid_q || push_o;
  assign word_o   = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_tready) begin
      valid_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid && s_tready) begin
      word_q <= word_d;
    end
  end

endmodule

>>> rtl/ssd_queue.sv
// Two-entry queue of segment words between front and back parts.
// Depends on ssd_pkg.

module ssd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ssd_pkg::seg_word_t  word_i,
  input  logic                pop_i,
  output ssd_pkg::seg_word_t  word_o,
  output ssd_pkg::ssd_qstat_t qstat_o
);
  import ssd_pkg::*;

  seg_word_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign qstat_o.empty = (cnt_q == 2'd0);
  assign qstat_o.full  = (cnt_q == 2'd2);
  assign word_o        = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

endmodule

>>> rtl/ssd_back.sv
// Back part: shifts each segment word out LSB first, one bit per beat,
// marking the final bit. Depends on ssd_pkg.

module ssd_back #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ssd_pkg::seg_word_t  word_i,
  input  ssd_pkg::ssd_qstat_t qstat_i,
  output logic                pop_o,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // [0] serial_bit, rest zero
  output logic                m_tlast
);
  import ssd_pkg::*;

  localparam int unsigned ExtW = (WORD_BITS > SegWordW) ? WORD_BITS : SegWordW;
  localparam int unsigned CntW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam logic [CntW-1:0] LastIdx = CntW'(WORD_BITS - 1);

  logic [ExtW-1:0]      ext_word;
  logic [WORD_BITS-1:0] sh_q;
  logic [CntW-1:0]      cnt_q;
  logic                 busy_q;
  logic                 last;

  assign ext_word = ExtW'(word_i);
  assign last     = (cnt_q == LastIdx);
  assign pop_o    = !qstat_i.empty && (!busy_q || (m_tready && last));

  assign m_tvalid = busy_q;
  assign m_tdata  = {7'd0, sh_q[0]};
  assign m_tlast  = last;

  // Shift sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q && m_tready) begin
      busy_q <= !last;
      cnt_q  <= cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sh_q <= ext_word[WORD_BITS-1:0];
    end else if (busy_q && m_tready) begin
      sh_q <= sh_q >> 1;
    end
  end

endmodule

>>> rtl/seven_segment_shift_driver_core.sv
// An update's first serial bit is valid after front register, queue and shifter.
// Throughput: WORD_BITS output beats per update, one per cycle while the
// sink is ready; the bit shifter in the back part sets that rate.
// Up to three further updates wait in the front register and 2-entry queue.
// Reset (rst_ni low, asynchronous) empties all stages; no output is valid.
// Top level: front, queue and back of the seven-segment shift driver.

module seven_segment_shift_driver_core #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] display_value, [11:10] point_position,
                                 // [12] bar_enable, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] serial_bit, rest zero
  output logic        m_tlast
);
  import ssd_pkg::*;

  ssd_qstat_t qstat;
  seg_word_t  front_word, queue_word;
  logic       push, pop;

  ssd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .qstat_i  (qstat),
    .push_o   (push),
    .word_o   (front_word)
  );

  ssd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .word_i  (front_word),
    .pop_i   (pop),
    .word_o  (queue_word),
    .qstat_o (qstat)
  );

  ssd_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .word_i   (queue_word),
    .qstat_i  (qstat),
    .pop_o    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> rtl/ssd_checker.sv
// Port-level checker for the seven-segment shift driver, bound to the
// top level. Depends only on the top-level ports.

module ssd_checker #(
  parameter int unsigned WORD_BITS = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast
);

  localparam int unsigned CntW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam logic [CntW-1:0] LastIdx = CntW'(WORD_BITS - 1);

  logic [CntW-1:0] beat_q;
  logic [2:0]      pend_q;
  logic            in_beat, out_beat, frame_done;

  assign in_beat    = s_tvalid && s_tready;
  assign out_beat   = m_tvalid && m_tready;
  assign frame_done = out_beat && m_tlast;

  // Beat position within a frame and updates still owed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
      pend_q <= 3'd0;
    end else begin
      if (out_beat) beat_q <= (beat_q == LastIdx) ? '0 : beat_q + CntW'(1);
      pend_q <= pend_q + 3'(in_beat) - 3'(frame_done);
    end
  end

  // Frame end marked on exactly the last bit position
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> (m_tlast == (beat_q == LastIdx)))
    else $error("tlast out of place in frame");

  // No output without an accepted update behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> (pend_q != 3'd0))
    else $error("output beat with no pending update");

  // Storage holds four updates at most
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q >= 3'd4) |-> !s_tready)
    else $error("input taken beyond capacity");

  // Stalled output holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output changed");

endmodule

bind seven_segment_shift_driver_core ssd_checker #(
  .WORD_BITS (WORD_BITS)
) u_ssd_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

>>> tb/sv/tb_seven_segment_shift_driver_core.sv
// Testbench for seven_segment_shift_driver_core: drives display updates and
// checks each serial beat against a local segment-word predictor.
// Depends on ssd_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb_seven_segment_shift_driver_core;
  import ssd_pkg::*;

  localparam int unsigned SerialBits  = 32;
  localparam int unsigned DirectedCnt = 20;
  localparam int unsigned RandomCnt   = 150;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned SettleCyc   = 40;

  typedef struct packed {
    logic serial;
    logic last;
  } serial_beat_t;

  typedef struct {
    logic [ValueW-1:0]   value;
    logic [PointW-1:0]   point;
    bit                  bar_on;
    bit                  typed;
    logic [SegWordW-1:0] word;
  } update_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [9:0] display_value, [11:10] point_position, [12] bar_enable
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [0] serial_bit
  logic        m_tlast;

  // Word typed into the directed table, used in place of the predictor
  bit                  typed_valid;
  logic [SegWordW-1:0] typed_word;

  bit src_steady;
  bit sink_steady;

  serial_beat_t pending_bits[$];
  int unsigned  mismatches;
  int unsigned  idle_cycles;

  update_row_t directed_rows [DirectedCnt];

  seven_segment_shift_driver_core #(
    .WORD_BITS(SerialBits)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pattern of the outer digits; the middle digit uses the same nibbles
  // moved inward by one position.
  function automatic logic [15:0] outer_pattern(input int unsigned digit);
    case (digit)
      0:       return 16'h7007;
      1:       return 16'h4001;
      2:       return 16'h300B;
      3:       return 16'h600B;
      4:       return 16'h400D;
      5:       return 16'h600E;
      6:       return 16'h700E;
      7:       return 16'h4003;
      8:       return 16'h700F;
      default: return 16'h600F;
    endcase
  endfunction

  function automatic logic [15:0] bar_pattern(input int unsigned level);
    case (level)
      0:       return 16'h0100;
      1:       return 16'h0300;
      2:       return 16'h0700;
      3:       return 16'h0F00;
      4:       return 16'h0F80;
      5:       return 16'h0FC0;
      6:       return 16'h0FE0;
      default: return 16'h0FF0;
    endcase
  endfunction

  // Full 32-bit display word for one update
  function automatic logic [SegWordW-1:0] segment_word(input logic [ValueW-1:0] value,
                                                      input logic [PointW-1:0] point,
                                                      input bit bar_on);
    int unsigned   v;
    int unsigned   level;
    logic [15:0]   hund;
    logic [15:0]   tens;
    logic [SegWordW-1:0] w;
    v     = 32'(value);
    hund  = outer_pattern((v / 100) % 10);
    tens  = outer_pattern((v / 10) % 10);
    w     = {hund, 16'h0000};
    w    |= {16'h0000, 4'h0, tens[15:12], tens[3:0], 4'h0};
    w    |= {16'h0000, outer_pattern(v % 10)};
    if (bar_on) begin
      level = (v * 8) / 500;
      if (level > 7) level = 7;
      w |= {bar_pattern(level), 16'h0000};
    end
    case (point)
      DpFirst:  w |= DpFirstBit;
      DpSecond: w |= DpSecondBit;
      DpThird:  w |= DpThirdBit;
      default:  ;
    endcase
    return w;
  endfunction

  // Output check, input capture and watchdog, all on the rising edge
  always @(posedge clk_i) begin : monitor
    serial_beat_t        got;
    serial_beat_t        want;
    logic [SegWordW-1:0] w;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got = '{serial: m_tdata[0], last: m_tlast};
        if (pending_bits.size() == 0) begin
          $error("unexpected output beat: serial_bit %0d, last_bit %0d", got.serial, got.last);
          mismatches++;
        end else begin
          want = pending_bits.pop_front();
          if (got.serial !== want.serial) begin
            $error("serial_bit mismatch: expected %0d, got %0d", want.serial, got.serial);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $error("last_bit mismatch: expected %0d, got %0d", want.last, got.last);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        w = typed_valid ? typed_word : segment_word(s_tdata[9:0], s_tdata[11:10], s_tdata[12]);
        for (int k = 0; k < SerialBits; k++) begin
          pending_bits.push_back('{serial: w[k], last: (k == SerialBits - 1)});
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // Sink: random stall before each beat, or none in steady stretches
  initial begin : sink
    int stall;
    m_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = sink_steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_tready = 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      @(negedge clk_i);
    end
  end

  // One update beat; entered and left at a falling edge
  task automatic send_update(input logic [ValueW-1:0] value, input logic [PointW-1:0] point,
                             input bit bar_on, input bit typed, input logic [SegWordW-1:0] word);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tdata     = {3'b000, bar_on, point, value};
    typed_valid = typed;
    typed_word  = word;
    s_tvalid    = 1'b1;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  // Hold the source off until every pending bit has been shifted out
  task automatic drain_display();
    s_tvalid = 1'b0;
    while (pending_bits.size() != 0) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned         pick;
    logic [ValueW-1:0]   value;
    logic [PointW-1:0]   point;
    rst_ni      = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    typed_valid = 1'b0;
    typed_word  = '0;
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    mismatches  = 0;
    idle_cycles = 0;

    // Digit extremes, bar thresholds, out-of-range hundreds, every point code
    directed_rows = '{
      '{10'd0,    DpNone,   1'b0, 1'b1, 32'h7007_7777},
      '{10'd888,  DpFirst,  1'b1, 1'b1, 32'hFFFF_77FF},
      '{10'd999,  DpThird,  1'b1, 1'b1, 32'h6FFF_E6FF},
      '{10'd1023, DpSecond, 1'b1, 1'b0, '0},
      '{10'd1000, DpNone,   1'b0, 1'b0, '0},
      '{10'd0,    DpNone,   1'b1, 1'b0, '0},
      '{10'd62,   DpFirst,  1'b1, 1'b0, '0},
      '{10'd63,   DpSecond, 1'b1, 1'b0, '0},
      '{10'd437,  DpNone,   1'b1, 1'b0, '0},
      '{10'd438,  DpThird,  1'b1, 1'b0, '0},
      '{10'd499,  DpNone,   1'b1, 1'b0, '0},
      '{10'd500,  DpFirst,  1'b1, 1'b0, '0},
      '{10'd512,  DpSecond, 1'b0, 1'b0, '0},
      '{10'd123,  DpThird,  1'b0, 1'b0, '0},
      '{10'd456,  DpFirst,  1'b0, 1'b0, '0},
      '{10'd789,  DpSecond, 1'b1, 1'b0, '0},
      '{10'd250,  DpNone,   1'b1, 1'b0, '0},
      '{10'd777,  DpThird,  1'b0, 1'b0, '0},
      '{10'd341,  DpFirst,  1'b1, 1'b0, '0},
      '{10'd606,  DpNone,   1'b0, 1'b0, '0}
    };

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_update(directed_rows[i].value, directed_rows[i].point, directed_rows[i].bar_on,
                  directed_rows[i].typed, directed_rows[i].word);
    end
    drain_display();

    // Random updates, with steady and stalling stretches on both sides
    for (int n = 0; n < RandomCnt; n++) begin
      if (n % 25 == 0) begin
        src_steady  = ($urandom_range(0, 3) == 0);
        sink_steady = ($urandom_range(0, 3) == 0);
      end
      if (n % 60 == 59) drain_display();
      pick = $urandom_range(0, 19);
      if (pick == 0)      value = ValueW'($urandom_range(1000, 1023));
      else if (pick == 1) value = ($urandom_range(0, 1) != 0) ? 10'd499 : 10'd500;
      else if (pick == 2) value = ($urandom_range(0, 1) != 0) ? 10'd0 : 10'd999;
      else                value = ValueW'($urandom_range(0, 999));
      point = PointW'($urandom_range(0, 3));
      send_update(value, point, 1'($urandom_range(0, 1)), 1'b0, '0);
    end

    // Wait out the tail, then keep watching for any stray beat
    drain_display();
    repeat (SettleCyc) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
